FILE: rtl/rtcm_pkg.sv
// ----------------------------------------------------------------------------
// RTCM3 frame receiver package
// Shared types and constants for the frame parser, the message store and the
// top level.
// ----------------------------------------------------------------------------
package rtcm_pkg;

    localparam logic [7:0] PREAMBLE      = 8'hD3;
    localparam logic [7:0] LEN_HIGH_MASK = 8'h03;
    localparam int         HEADER_BYTES  = 3;
    localparam int         TRAILER_BYTES = 3;
    localparam int         FRAME_EXTRA   = HEADER_BYTES + TRAILER_BYTES;

    localparam logic [11:0] RESET_TYPE_A = 12'd1005;
    localparam logic [11:0] RESET_TYPE_B = 12'd1077;
    localparam logic [11:0] RESET_TYPE_C = 12'd1087;
    localparam logic [11:0] RESET_TYPE_D = 12'd1230;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TYPE_A = 2'd0;
    localparam logic [1:0] CFG_TYPE_B = 2'd1;
    localparam logic [1:0] CFG_TYPE_C = 2'd2;
    localparam logic [1:0] CFG_TYPE_D = 2'd3;

    // Input item modes and result kinds.
    localparam logic MODE_LINK   = 1'b0;
    localparam logic MODE_READ   = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_REJECTED = 2'd1,
        ST_TOO_LONG = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic [11:0] type_a;
        logic [11:0] type_b;
        logic [11:0] type_c;
        logic [11:0] type_d;
    } accept_types_t;

    // Frame report produced by the parser for the current byte.
    typedef struct packed {
        logic          valid;
        frame_status_t status;
        logic [11:0]   msg_type;
        logic [9:0]    length;
        logic [2:0]    slot;
    } report_t;

    // Store write produced by the parser for the current byte.
    typedef struct packed {
        logic        en;
        logic [10:0] offset;
        logic [7:0]  data;
    } store_wr_t;

endpackage

FILE: rtl/rtcm_in_if.sv
// ----------------------------------------------------------------------------
// RTCM3 receiver input channel
// Valid/ready channel carrying link bytes and stored-byte read requests.
// ----------------------------------------------------------------------------
interface rtcm_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_data;
    logic [2:0] read_slot;
    logic [9:0] read_offset;

    modport source (output valid, output mode, output rx_data, output read_slot,
                    output read_offset, input ready);
    modport sink (input valid, input mode, input rx_data, input read_slot,
                  input read_offset, output ready);
endinterface

FILE: rtl/rtcm_out_if.sv
// ----------------------------------------------------------------------------
// RTCM3 receiver output channel
// Valid/ready channel carrying frame reports and read data.
// ----------------------------------------------------------------------------
interface rtcm_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  frame_status;
    logic [11:0] message_type;
    logic [9:0]  payload_length;
    logic [2:0]  frame_slot;
    logic [7:0]  read_data;

    modport source (output valid, output kind, output frame_status, output message_type,
                    output payload_length, output frame_slot, output read_data,
                    input ready);
    modport sink (input valid, input kind, input frame_status, input message_type,
                  input payload_length, input frame_slot, input read_data,
                  output ready);
endinterface

FILE: rtl/rtcm_parse.sv
// ----------------------------------------------------------------------------
// RTCM3 frame parser
// Tracks the frame phase, byte count, length, type and write slot, and turns
// each link byte into a store write and, at frame end, a report.
// ----------------------------------------------------------------------------
module rtcm_parse
    import rtcm_pkg::*;
#(
    parameter int SLOTS       = 8,
    parameter int MAX_PAYLOAD = 1018,
    parameter int SLOT_W      = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic [7:0]        byte_data,
    input  accept_types_t     accept_types,
    output store_wr_t         store_wr,
    output logic [SLOT_W-1:0] write_slot,
    output report_t           report
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [10:0]       count_reg, count_next;
    logic [9:0]        length_reg, length_next;
    logic [11:0]       type_reg, type_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [10:0] count_inc;
    logic        type_ok;

    assign count_inc  = count_reg + 11'd1;
    assign write_slot = slot_reg;

    assign type_ok = (type_next == accept_types.type_a) || (type_next == accept_types.type_b)
                  || (type_next == accept_types.type_c) || (type_next == accept_types.type_d);

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        length_next     = length_reg;
        type_next       = type_reg;
        slot_next       = slot_reg;
        store_wr.en     = 1'b0;
        store_wr.offset = count_reg;
        store_wr.data   = byte_data;
        report.valid    = 1'b0;
        report.status   = ST_ACCEPTED;
        report.msg_type = 12'd0;
        report.length   = length_reg;
        report.slot     = 3'(slot_reg);

        case (phase_reg)
            PH_HUNT:
            begin
                store_wr.offset = 11'd0;
                if (byte_data == PREAMBLE)
                begin
                    store_wr.en = 1'b1;
                    count_next  = 11'd1;
                    type_next   = 12'd0;
                    phase_next  = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                store_wr.en     = 1'b1;
                store_wr.offset = 11'd1;
                count_next      = 11'd2;
                length_next     = {byte_data[1:0] & LEN_HIGH_MASK[1:0], 8'd0};
                phase_next      = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                store_wr.en     = 1'b1;
                store_wr.offset = 11'd2;
                length_next     = {length_reg[9:8], byte_data};
                report.length   = length_next;
                if (length_next > 10'(MAX_PAYLOAD))
                begin
                    report.valid  = 1'b1;
                    report.status = ST_TOO_LONG;
                    count_next    = 11'd0;
                    phase_next    = PH_HUNT;
                end
                else
                begin
                    count_next = 11'd3;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                store_wr.en = 1'b1;
                if (count_reg == 11'd3)
                begin
                    type_next = {byte_data, 4'd0};
                end
                else if (count_reg == 11'd4)
                begin
                    type_next = type_reg | {8'd0, byte_data[7:4]};
                end
                count_next = count_inc;
                if ({1'b0, count_inc} >= ({2'd0, length_reg} + 12'(FRAME_EXTRA)))
                begin
                    report.valid    = 1'b1;
                    report.status   = type_ok ? ST_ACCEPTED : ST_REJECTED;
                    report.msg_type = type_next;
                    if (type_ok)
                    begin
                        slot_next = (slot_reg == SLOT_W'(SLOTS - 1)) ? '0
                                                                     : slot_reg + 1'b1;
                    end
                    count_next = 11'd0;
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            count_reg  <= 11'd0;
            length_reg <= 10'd0;
            type_reg   <= 12'd0;
            slot_reg   <= '0;
        end
        else if (byte_valid)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            type_reg   <= type_next;
            slot_reg   <= slot_next;
        end
    end

endmodule

FILE: rtl/rtcm_store.sv
// ----------------------------------------------------------------------------
// RTCM3 message store
// Single-port byte memory holding the ring of message slots, with a
// registered read.
// ----------------------------------------------------------------------------
module rtcm_store
    import rtcm_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int SLOT_BYTES = 1024,
    parameter int SLOT_W     = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  store_wr_t         wr,
    input  logic              wr_active,
    input  logic [SLOT_W-1:0] wr_slot,
    input  logic              rd_en,
    input  logic [2:0]        rd_slot,
    input  logic [9:0]        rd_offset,
    output logic [7:0]        rd_data
);

    localparam int DEPTH  = SLOTS * SLOT_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_in_range;
    logic              rd_in_range;
    logic [7:0]        rd_data_reg;
    logic              rd_hit_reg;

    // Slot base is a multiply by a constant; the write slot is SLOT_W bits, the read slot three.
    assign wr_addr     = ADDR_W'(32'(wr_slot) * SLOT_BYTES + 32'(wr.offset));
    assign rd_addr     = ADDR_W'(32'(rd_slot) * SLOT_BYTES + 32'(rd_offset));
    assign wr_in_range = 32'(wr.offset) < SLOT_BYTES;
    assign rd_in_range = (32'(rd_slot) < SLOTS) && (32'(rd_offset) < SLOT_BYTES);

    always_ff @(posedge clk)
    begin
        if (wr_active && wr.en && wr_in_range)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en && rd_in_range)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            rd_hit_reg <= rd_in_range;
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : 8'd0;

endmodule

FILE: rtl/rtcm3_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// RTCM3 frame receiver unit
// Link bytes and read requests enter on one valid/ready channel at up to one
// transfer per clock. Link bytes are deframed: the unit hunts for the 0xD3
// preamble, takes the 10-bit length, stores every frame byte from the
// preamble on into the current slot of a ring of SLOTS message slots, and at
// frame end reports status, message type, length and slot. The slot advances
// only when the message type matches one of the four configured accepted
// types; a frame longer than MAX_PAYLOAD is reported right after its length
// bytes. A read request returns one stored byte from any slot; reading a
// byte that was never written gives an undefined value. The CRC is not
// checked. Each item is either one write or one read in the single-port
// message store, so the unit sustains one transfer per cycle while the
// output side keeps draining results; a result passes through the stage
// one register and then the output register before it is offered. The
// store needs no clearing after reset. Configuration registers should only
// be written while the unit is idle.
// ----------------------------------------------------------------------------
module rtcm3_frame_receiver_unit
    import rtcm_pkg::*;
#(
    parameter int SLOTS       = 8,
    parameter int MAX_PAYLOAD = 1018,
    parameter int SLOT_BYTES  = 1024
)
(
    input  logic          clk,
    input  logic          rst_n,
    rtcm_in_if.sink       link,
    rtcm_out_if.source    result,
    input  logic          cfg_write_en,
    input  logic [1:0]    cfg_index,
    input  logic [11:0]   cfg_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Accepted message type registers.
    accept_types_t cfg_reg;

    // Stage one holds the result of an accepted item, until the output register
    // takes it, in step with the store's registered read data.
    logic          s1_valid_reg;
    logic          s1_kind_reg;
    frame_status_t s1_status_reg;
    logic [11:0]   s1_type_reg;
    logic [9:0]    s1_length_reg;
    logic [2:0]    s1_slot_reg;

    // Output register.
    logic          out_valid_reg;
    logic          out_kind_reg;
    frame_status_t out_status_reg;
    logic [11:0]   out_type_reg;
    logic [9:0]    out_length_reg;
    logic [2:0]    out_slot_reg;
    logic [7:0]    out_data_reg;

    logic              accept;
    logic              link_byte;
    logic              read_req;
    logic              s1_advance;
    logic              has_result;
    store_wr_t         store_wr;
    logic [SLOT_W-1:0] write_slot;
    report_t           report;
    logic [7:0]        store_data;

    // Stage one moves on whenever the output register is empty or is being
    // drained; a new transfer is taken whenever stage one is free or moving.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || result.ready);
    assign link.ready = !s1_valid_reg || s1_advance;
    assign accept     = link.valid && link.ready;
    assign link_byte  = accept && (link.mode == MODE_LINK);
    assign read_req   = accept && (link.mode == MODE_READ);
    assign has_result = read_req || (link_byte && report.valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.type_a <= RESET_TYPE_A;
            cfg_reg.type_b <= RESET_TYPE_B;
            cfg_reg.type_c <= RESET_TYPE_C;
            cfg_reg.type_d <= RESET_TYPE_D;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_TYPE_A: cfg_reg.type_a <= cfg_data;
                CFG_TYPE_B: cfg_reg.type_b <= cfg_data;
                CFG_TYPE_C: cfg_reg.type_c <= cfg_data;
                CFG_TYPE_D: cfg_reg.type_d <= cfg_data;
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    rtcm_parse #(
        .SLOTS       (SLOTS),
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .SLOT_W      (SLOT_W)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (link_byte),
        .byte_data    (link.rx_data),
        .accept_types (cfg_reg),
        .store_wr     (store_wr),
        .write_slot   (write_slot),
        .report       (report)
    );

    // Each transfer is either a store write or a store read, so the single
    // port is never contended and a read always sees every earlier write.
    rtcm_store #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES),
        .SLOT_W     (SLOT_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (store_wr),
        .wr_active (link_byte),
        .wr_slot   (write_slot),
        .rd_en     (read_req),
        .rd_slot   (link.read_slot),
        .rd_offset (link.read_offset),
        .rd_data   (store_data)
    );

    // Stage one control and payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= has_result;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_result)
        begin
            if (read_req)
            begin
                s1_kind_reg   <= KIND_READ;
                s1_status_reg <= ST_ACCEPTED;
                s1_type_reg   <= 12'd0;
                s1_length_reg <= 10'd0;
                s1_slot_reg   <= 3'd0;
            end
            else
            begin
                s1_kind_reg   <= KIND_REPORT;
                s1_status_reg <= report.status;
                s1_type_reg   <= report.msg_type;
                s1_length_reg <= report.length;
                s1_slot_reg   <= report.slot;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_kind_reg   <= s1_kind_reg;
            out_status_reg <= s1_status_reg;
            out_type_reg   <= s1_type_reg;
            out_length_reg <= s1_length_reg;
            out_slot_reg   <= s1_slot_reg;
            out_data_reg   <= (s1_kind_reg == KIND_READ) ? store_data : 8'd0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = out_kind_reg;
    assign result.frame_status   = out_status_reg;
    assign result.message_type   = out_type_reg;
    assign result.payload_length = out_length_reg;
    assign result.frame_slot     = out_slot_reg;
    assign result.read_data      = out_data_reg;

`ifndef NO_ASSERTIONS
    // A pending result is never dropped while the output register is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !result.ready |=> s1_valid_reg)
    else $error("stage one result lost while output stalled");

    // No new transfer is taken while both result registers are full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !result.ready |-> !link.ready)
    else $error("input taken while pipeline was full");

    // The ring's write slot always names an existing slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(write_slot) < SLOTS)
    else $error("write slot out of range");

    // Every accepted read request leaves a read result in stage one.
    assert property (@(posedge clk) disable iff (!rst_n)
        read_req |=> s1_valid_reg && (s1_kind_reg == KIND_READ))
    else $error("read request produced no read result");
`endif

endmodule
